[sv/fclf_pkg.sv]
// shared types, constants and helpers of the foot contact lock filter
package fclf_pkg;

    // position format and derived datapath widths
    localparam int POS_W   = 32;
    localparam int MAX_W   = (POS_W > 32) ? POS_W : 32;
    localparam int DIF_W   = MAX_W + 1;
    localparam int SUM_W   = DIF_W + 2;
    localparam int BLD_W   = 17;
    localparam int PRD_W   = DIF_W + BLD_W;
    localparam int CFG_W   = 32;
    localparam int SPD_W   = 31;
    localparam int SMAG_W  = 31;
    localparam int SQ_W    = 2 * SMAG_W;
    localparam int ACC_W   = SQ_W + 2;
    localparam int S900_W  = SQ_W + 10;
    localparam int BPRD_W  = 2 * BLD_W;
    localparam int PADDR_W = 4;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 4;

    localparam logic [BLD_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [BLD_W-1:0] HALF_Q16 = 17'h08000;

    // register reset values
    localparam logic signed [CFG_W-1:0] GROUND_RST = 32'sd0;
    localparam logic signed [CFG_W-1:0] HEIGHT_RST = 32'sd6554;
    localparam logic [SPD_W-1:0]        SPEED_RST  = 31'd32768;
    localparam logic [BLD_W-1:0]        RATE_RST   = 17'd19661;

    // lane sequencer steps
    localparam logic [STEP_W-1:0] STP_DIFF = 4'd0;
    localparam logic [STEP_W-1:0] STP_SQR  = 4'd1;
    localparam logic [STEP_W-1:0] STP_SUM  = 4'd2;
    localparam logic [STEP_W-1:0] STP_S900 = 4'd3;
    localparam logic [STEP_W-1:0] STP_CONT = 4'd4;
    localparam logic [STEP_W-1:0] STP_BMUL = 4'd5;
    localparam logic [STEP_W-1:0] STP_BLND = 4'd6;
    localparam logic [STEP_W-1:0] STP_EDIF = 4'd7;
    localparam logic [STEP_W-1:0] STP_EMUL = 4'd8;
    localparam logic [STEP_W-1:0] STP_EOUT = 4'd9;
    localparam logic [STEP_W-1:0] STP_TDIF = 4'd10;
    localparam logic [STEP_W-1:0] STP_TMUL = 4'd11;
    localparam logic [STEP_W-1:0] STP_TOUT = 4'd12;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [DIF_W-1:0] dif_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [BLD_W-1:0]        blend_t;

    typedef enum logic [1:0] {
        REG_GROUND,
        REG_HEIGHT,
        REG_SPEED,
        REG_RATE
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] ground;
        logic signed [CFG_W-1:0] height;
        logic [SPD_W-1:0]        speed;
        blend_t                  rate;
    } cfg_t;

    typedef struct packed {
        pos_t x;
        pos_t y;
        pos_t z;
        pos_t toe;
    } foot_t;

    typedef struct packed {
        logic   contact;
        blend_t blend;
        pos_t   x;
        pos_t   y;
        pos_t   z;
        pos_t   toe;
    } lane_res_t;

    typedef struct packed {
        logic clip_start;
        pos_t left_foot_x;
        pos_t left_foot_y;
        pos_t left_foot_z;
        pos_t left_toe_y;
        pos_t right_foot_x;
        pos_t right_foot_y;
        pos_t right_foot_z;
        pos_t right_toe_y;
    } in_item_t;

    typedef struct packed {
        logic   left_contact;
        logic   right_contact;
        blend_t left_blend;
        blend_t right_blend;
        pos_t   out_left_x;
        pos_t   out_left_y;
        pos_t   out_left_z;
        pos_t   out_left_toe;
        pos_t   out_right_x;
        pos_t   out_right_y;
        pos_t   out_right_z;
        pos_t   out_right_toe;
    } out_item_t;

    // clamp a widened sum into the position range
    function automatic pos_t sat_pos(input sum_t v);
        sum_t hi;
        sum_t lo;
        pos_t r;
        hi = sum_t'({{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
        lo = sum_t'({{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}});
        r  = v[POS_W-1:0];
        if (v > hi)
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

[sv/fclf_chan_if.sv]
// valid/ready channel interfaces for frames in and corrected feet out
interface fclf_in_if;
    import fclf_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fclf_out_if;
    import fclf_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/foot_contact_lock_filter.sv]
// top level: frame channel, two foot lanes, result merge and config port
//
// frame_ch carries one skeleton frame per transfer (both feet and toes,
// signed Q16.16) plus a clip_start flag; result_ch carries one corrected
// frame per transfer: contact flags, smoothed blends (Q1.16) and the
// corrected foot and toe positions
// the left and right feet are processed side by side in two identical
// lanes; each lane runs a fixed 13-step sequence (speed squares, x900
// compare, blend multiply, three position multiplies, toe multiply)
// frame_ch.ready stays low while a frame is in the lanes or waits to merge
// the output register lets a new frame in while the last result waits;
// a stalled result_ch holds that result and the next one waits in the lanes
// reset clears control, blends, contact history and locks, and restores the
// register defaults; the first frame after reset is treated as a clip start
// apb registers: 0 ground height, 4 height threshold, 8 speed threshold,
// 12 smoothing rate; write only while no frame is in flight
module foot_contact_lock_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    fclf_in_if.sink                       frame_ch,
    fclf_out_if.source                    result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fclf_pkg::PADDR_W-1:0]  paddr,
    input  logic [fclf_pkg::DATA_W-1:0]   pwdata,
    output logic [fclf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import fclf_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       have_prev_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       accept;
    logic       first;
    logic       load;
    logic       in_ready;
    logic       l_done, r_done;
    lane_res_t  l_res, r_res;
    foot_t      l_foot, r_foot;
    cfg_t       cfg;

    // register file
    fclf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame transfer and clip boundary
    assign accept = frame_ch.valid && in_ready;
    assign first  = frame_ch.data.clip_start || !have_prev_reg;

    assign l_foot.x   = frame_ch.data.left_foot_x;
    assign l_foot.y   = frame_ch.data.left_foot_y;
    assign l_foot.z   = frame_ch.data.left_foot_z;
    assign l_foot.toe = frame_ch.data.left_toe_y;
    assign r_foot.x   = frame_ch.data.right_foot_x;
    assign r_foot.y   = frame_ch.data.right_foot_y;
    assign r_foot.z   = frame_ch.data.right_foot_z;
    assign r_foot.toe = frame_ch.data.right_toe_y;

    // two foot lanes share the start and finish together
    fclf_lane u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .first (first),
        .foot  (l_foot),
        .cfg   (cfg),
        .done  (l_done),
        .res   (l_res)
    );

    fclf_lane u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .first (first),
        .foot  (r_foot),
        .cfg   (cfg),
        .done  (r_done),
        .res   (r_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (l_done)
                begin
                    state_next = load ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs: frame ready and merge into the output register
    always_comb
    begin
        in_ready = 1'b0;
        load     = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  load = l_done && (!out_valid_reg || result_ch.ready);
            ST_HOLD: load = !out_valid_reg || result_ch.ready;
            default: ;
        endcase
    end

    // merge stage: gather both lanes into one result
    always_comb
    begin
        out_data_next.left_contact  = l_res.contact;
        out_data_next.right_contact = r_res.contact;
        out_data_next.left_blend    = l_res.blend;
        out_data_next.right_blend   = r_res.blend;
        out_data_next.out_left_x    = l_res.x;
        out_data_next.out_left_y    = l_res.y;
        out_data_next.out_left_z    = l_res.z;
        out_data_next.out_left_toe  = l_res.toe;
        out_data_next.out_right_x   = r_res.x;
        out_data_next.out_right_y   = r_res.y;
        out_data_next.out_right_z   = r_res.z;
        out_data_next.out_right_toe = r_res.toe;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                have_prev_reg <= 1'b1;
            end
        end
    end

    // result payload holds until the next merge
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign frame_ch.ready  = in_ready;
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    // both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        l_done == r_done)
        else $error("foot lanes finished out of step");

    // lanes only finish while the controller waits for them
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        l_done |-> state_reg == ST_RUN)
        else $error("lane finished outside of run state");

    // a frame transfer starts the lanes and closes the frame channel
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && !frame_ch.ready)
        else $error("frame transfer did not start the lanes");

    // blends never leave the unit range
    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (out_data_reg.left_blend <= ONE_Q16)
                            && (out_data_reg.right_blend <= ONE_Q16))
        else $error("blend above one");

endmodule

[sv/fclf_cfg.sv]
// apb register file holding ground, thresholds and smoothing rate
module fclf_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fclf_pkg::PADDR_W-1:0]  paddr,
    input  logic [fclf_pkg::DATA_W-1:0]   pwdata,
    output logic [fclf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output fclf_pkg::cfg_t                cfg
);
    import fclf_pkg::*;

    logic signed [CFG_W-1:0] ground_reg, ground_next;
    logic signed [CFG_W-1:0] height_reg, height_next;
    logic [SPD_W-1:0]        speed_reg, speed_next;
    blend_t                  rate_reg, rate_next;
    logic                    wr;
    reg_idx_t                idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_comb
    begin
        ground_next = ground_reg;
        height_next = height_reg;
        speed_next  = speed_reg;
        rate_next   = rate_reg;
        if (wr)
        begin
            case (idx)
                REG_GROUND: ground_next = pwdata;
                REG_HEIGHT: height_next = pwdata;
                REG_SPEED:  speed_next  = pwdata[SPD_W-1:0];
                REG_RATE:   rate_next   = pwdata[BLD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GROUND: prdata = ground_reg;
            REG_HEIGHT: prdata = height_reg;
            REG_SPEED:  prdata = DATA_W'(speed_reg);
            REG_RATE:   prdata = DATA_W'(rate_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_reg <= GROUND_RST;
            height_reg <= HEIGHT_RST;
            speed_reg  <= SPEED_RST;
            rate_reg   <= RATE_RST;
        end
        else
        begin
            ground_reg <= ground_next;
            height_reg <= height_next;
            speed_reg  <= speed_next;
            rate_reg   <= rate_next;
        end
    end

    assign cfg.ground = ground_reg;
    assign cfg.height = height_reg;
    assign cfg.speed  = speed_reg;
    assign cfg.rate   = rate_reg;

endmodule

[sv/fclf_lane.sv]
// per-foot lane: contact test, blend smoothing, foot lock and toe flattening
module fclf_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                first,
    input  fclf_pkg::foot_t     foot,
    input  fclf_pkg::cfg_t      cfg,
    output logic                done,
    output fclf_pkg::lane_res_t res
);
    import fclf_pkg::*;

    // sequencer and carried state
    logic              active_reg, active_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    blend_t            blend_reg, blend_next;
    logic              pc_reg;
    pos_t              lock_x_reg, lock_z_reg;
    logic              relock;

    // frame payload
    pos_t              px_reg, py_reg, pz_reg, pt_reg;
    logic              first_reg;
    pos_t              prv_reg [3];
    pos_t              cur_pos [3];

    // speed test
    logic [SMAG_W-1:0] smag_reg [3];
    logic [SMAG_W-1:0] smag_next [3];
    logic              big_reg, big_next;
    logic              hcond_reg, hcond_next;
    logic [SQ_W-1:0]   tsq_reg, tsq_next;
    logic [SQ_W-1:0]   sq_reg [3];
    logic [SQ_W-1:0]   sq_next [3];
    logic [ACC_W-1:0]  sum_reg, sum_next;
    logic [S900_W-1:0] s900_reg, s900_next;
    logic              ovf_reg, ovf_next;
    logic              contact_reg, contact_next;

    // blend
    logic [BPRD_W-1:0] bprod_reg, bprod_next;

    // position correction
    logic [DIF_W-1:0]  emag_reg [3];
    logic [DIF_W-1:0]  emag_next [3];
    logic              eneg_reg [3];
    logic              eneg_next [3];
    logic [PRD_W-1:0]  eprod_reg [3];
    logic [PRD_W-1:0]  eprod_next [3];
    pos_t              opos_reg [3];
    pos_t              opos_next [3];
    logic [DIF_W-1:0]  dmag_reg, dmag_next;
    blend_t            wgt_reg, wgt_next;
    logic [PRD_W-1:0]  tprod_reg, tprod_next;
    pos_t              ot_reg, ot_next;

    assign cur_pos[0] = px_reg;
    assign cur_pos[1] = py_reg;
    assign cur_pos[2] = pz_reg;

    always_comb
    begin
        dif_t               sd;
        logic [DIF_W-1:0]   su;
        dif_t               e [3];
        logic [S900_W-1:0]  sx;
        logic               slow;
        blend_t             rate_c;
        blend_t             bmag;
        logic [BPRD_W:0]    brnd;
        logic signed [19:0] nb;
        blend_t             bclamp;
        logic [PRD_W:0]     erd;
        sum_t               v;
        dif_t               dt;
        logic [PRD_W:0]     trd;
        sum_t               vt;

        // frame-to-frame displacement, ground height test, threshold square
        big_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sd = dif_t'(cur_pos[i]) - dif_t'(prv_reg[i]);
            su = sd[DIF_W-1] ? DIF_W'(-sd) : DIF_W'(sd);
            smag_next[i] = su[SMAG_W-1:0];
            big_next = big_next | (|su[DIF_W-1:SMAG_W]);
            sq_next[i] = smag_reg[i] * smag_reg[i];
        end
        hcond_next = (dif_t'(py_reg) - dif_t'($signed(cfg.ground))) < dif_t'($signed(cfg.height));
        tsq_next   = cfg.speed * cfg.speed;

        sum_next = ACC_W'(sq_reg[0]) + ACC_W'(sq_reg[1]) + ACC_W'(sq_reg[2]);

        // times 900 as 1024 - 128 + 4
        sx        = S900_W'(sum_reg[SQ_W-1:0]);
        s900_next = (sx << 10) - (sx << 7) + (sx << 2);
        ovf_next  = |sum_reg[ACC_W-1:SQ_W];

        slow = first_reg ? (cfg.speed != '0)
                         : (!big_reg && !ovf_reg && (s900_reg < S900_W'(tsq_reg)));
        contact_next = slow && hcond_reg;

        // exponential blend toward one or zero
        rate_c     = (cfg.rate > ONE_Q16) ? ONE_Q16 : cfg.rate;
        bmag       = contact_reg ? (ONE_Q16 - blend_reg) : blend_reg;
        bprod_next = bmag * rate_c;
        brnd       = (BPRD_W+1)'(bprod_reg) + (BPRD_W+1)'(HALF_Q16);
        nb = contact_reg ? ($signed({3'b000, blend_reg}) + $signed({1'b0, brnd[BPRD_W:16]}))
                         : ($signed({3'b000, blend_reg}) - $signed({1'b0, brnd[BPRD_W:16]}));
        if (nb < 0)
        begin
            bclamp = '0;
        end
        else if (nb > $signed({3'b000, ONE_Q16}))
        begin
            bclamp = ONE_Q16;
        end
        else
        begin
            bclamp = nb[BLD_W-1:0];
        end
        blend_next = first_reg ? (contact_reg ? ONE_Q16 : '0) : bclamp;
        relock     = first_reg || (contact_reg && !pc_reg);

        // pull toward locked x, ground height and locked z
        e[0] = dif_t'(lock_x_reg) - dif_t'(px_reg);
        e[1] = dif_t'($signed(cfg.ground)) - dif_t'(py_reg);
        e[2] = dif_t'(lock_z_reg) - dif_t'(pz_reg);
        for (int i = 0; i < 3; i++)
        begin
            eneg_next[i]  = e[i][DIF_W-1];
            emag_next[i]  = e[i][DIF_W-1] ? DIF_W'(-e[i]) : DIF_W'(e[i]);
            eprod_next[i] = emag_reg[i] * blend_reg;
            erd = (PRD_W+1)'(eprod_reg[i]) + (PRD_W+1)'(HALF_Q16);
            v = eneg_reg[i] ? (sum_t'(cur_pos[i]) - $signed({2'b00, erd[DIF_W+15:16]}))
                            : (sum_t'(cur_pos[i]) + $signed({2'b00, erd[DIF_W+15:16]}));
            opos_next[i] = contact_reg ? sat_pos(v) : cur_pos[i];
        end

        // toe flattening
        dt         = dif_t'(pt_reg) - dif_t'(opos_reg[1]);
        dmag_next  = dt[DIF_W-1] ? '0 : DIF_W'(dt);
        wgt_next   = ONE_Q16 - blend_reg;
        tprod_next = dmag_reg * wgt_reg;
        trd        = (PRD_W+1)'(tprod_reg) + (PRD_W+1)'(HALF_Q16);
        vt         = sum_t'($signed(cfg.ground)) + $signed({2'b00, trd[DIF_W+15:16]});
        ot_next    = contact_reg ? sat_pos(vt) : pt_reg;

        // sequencer
        done_next = active_reg && (step_reg == STP_TOUT);
        if (start)
        begin
            active_next = 1'b1;
            step_next   = STP_DIFF;
        end
        else if (active_reg)
        begin
            active_next = (step_reg != STP_TOUT);
            step_next   = step_reg + 1'b1;
        end
        else
        begin
            active_next = 1'b0;
            step_next   = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STP_DIFF;
            done_reg   <= 1'b0;
            blend_reg  <= '0;
            pc_reg     <= 1'b0;
            lock_x_reg <= '0;
            lock_z_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            if (active_reg && (step_reg == STP_BLND))
            begin
                blend_reg <= blend_next;
                pc_reg    <= contact_reg;
                if (relock)
                begin
                    lock_x_reg <= px_reg;
                    lock_z_reg <= pz_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg    <= foot.x;
            py_reg    <= foot.y;
            pz_reg    <= foot.z;
            pt_reg    <= foot.toe;
            first_reg <= first;
        end
        if (active_reg)
        begin
            case (step_reg)
                STP_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        smag_reg[i] <= smag_next[i];
                        prv_reg[i]  <= cur_pos[i];
                    end
                    big_reg   <= big_next;
                    hcond_reg <= hcond_next;
                    tsq_reg   <= tsq_next;
                end
                STP_SQR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sq_reg[i] <= sq_next[i];
                    end
                end
                STP_SUM:  sum_reg <= sum_next;
                STP_S900:
                begin
                    s900_reg <= s900_next;
                    ovf_reg  <= ovf_next;
                end
                STP_CONT: contact_reg <= contact_next;
                STP_BMUL: bprod_reg <= bprod_next;
                STP_EDIF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        emag_reg[i] <= emag_next[i];
                        eneg_reg[i] <= eneg_next[i];
                    end
                end
                STP_EMUL:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eprod_reg[i] <= eprod_next[i];
                    end
                end
                STP_EOUT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        opos_reg[i] <= opos_next[i];
                    end
                end
                STP_TDIF:
                begin
                    dmag_reg <= dmag_next;
                    wgt_reg  <= wgt_next;
                end
                STP_TMUL: tprod_reg <= tprod_next;
                STP_TOUT: ot_reg <= ot_next;
                default:  ;
            endcase
        end
    end

    assign done        = done_reg;
    assign res.contact = contact_reg;
    assign res.blend   = blend_reg;
    assign res.x       = opos_reg[0];
    assign res.y       = opos_reg[1];
    assign res.z       = opos_reg[2];
    assign res.toe     = ot_reg;

endmodule
